>>> hdl/rle_pkg.sv
package rle_pkg;

  localparam int BUF_DEPTH = 128;
  localparam int ADDR_W    = 7;
  localparam int CNT_W     = 8;
  localparam int LANES     = 4;
  localparam int NUM_W     = 3;
  localparam int TDATA_W   = 40;
  localparam int PAD_W     = TDATA_W - NUM_W - LANES * 8;

  localparam logic [7:0] THR_RESET = 8'd3;
  localparam logic [7:0] THR_MIN   = 8'd2;
  localparam logic [7:0] END_CODE  = 8'd128;
  localparam int         RUN_BASE  = 257;

  localparam logic OP_DATA = 1'b0;
  localparam logic OP_END  = 1'b1;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_LIT   = 2'd1,
    MODE_RUN   = 2'd2
  } rle_mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HDR,
    S_MEM,
    S_REP,
    S_END
  } rle_state_t;

  // one encoded byte on its way to the packer
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       fin;
  } rle_byte_t;

  // one packed result
  typedef struct packed {
    logic [NUM_W-1:0]       count;
    logic [LANES-1:0][7:0]  lanes;
    logic                   last;
    logic                   fin;
  } rle_chunk_t;

  function automatic logic [7:0] run_hdr(input logic [CNT_W-1:0] len);
    logic [8:0] d;
    d = 9'(RUN_BASE) - {1'b0, len};
    return d[7:0];
  endfunction

endpackage

>>> hdl/rle_ctrl.sv
module rle_ctrl
  import rle_pkg::*;
#(
  parameter int MAX_SEGMENT = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] thr_cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_op,
  input  logic [7:0] in_byte,
  output logic       b_valid,
  input  logic       b_ready,
  output rle_byte_t  b_out
);

  localparam logic [CNT_W-1:0] MAX_SEG = CNT_W'(MAX_SEGMENT);

  rle_state_t        state_r, state_nxt;
  rle_mode_t         mode_r, mode_nxt;
  logic [ADDR_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  trail_r, trail_nxt;
  logic [7:0]        last_r, last_nxt;
  logic              wr_defer_r, wr_defer_nxt;

  // per-transaction job description
  logic [7:0]        hdr_r, hdr_nxt;
  logic [7:0]        rep_r, rep_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [ADDR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic              body_mem_r, body_mem_nxt;
  logic              end_en_r, end_en_nxt;

  logic [7:0]        mem [BUF_DEPTH];
  logic [7:0]        rd_data_r;
  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;

  logic [7:0]        thr;

  always_comb begin
    thr = thr_cfg;
    if (thr_cfg < THR_MIN) begin
      thr = THR_MIN;
    end else if (thr_cfg > MAX_SEG) begin
      thr = MAX_SEG;
    end
  end

  always_comb begin
    logic             same;
    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W-1:0] trail_new;
    logic [CNT_W-1:0] lit_len;
    same      = (in_byte == last_r);
    cnt_inc   = cnt_r + 1'b1;
    trail_new = same ? trail_r + 1'b1 : CNT_W'(1);
    lit_len   = cnt_inc - trail_new;

    state_nxt    = state_r;
    mode_nxt     = mode_r;
    head_nxt     = head_r;
    cnt_nxt      = cnt_r;
    trail_nxt    = trail_r;
    last_nxt     = last_r;
    wr_defer_nxt = wr_defer_r;
    hdr_nxt      = hdr_r;
    rep_nxt      = rep_r;
    rem_nxt      = rem_r;
    rd_ptr_nxt   = rd_ptr_r;
    body_mem_nxt = body_mem_r;
    end_en_nxt   = end_en_r;
    wr_en        = 1'b0;
    wr_addr      = head_r + cnt_r[ADDR_W-1:0];
    wr_data      = in_byte;
    rd_en        = 1'b0;
    in_ready     = 1'b0;
    b_valid      = 1'b0;
    b_out        = '0;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          wr_defer_nxt = 1'b0;
          end_en_nxt   = 1'b0;
          if (in_op == OP_DATA) begin
            case (mode_r)
              MODE_RUN: begin
                if (same && cnt_r < MAX_SEG) begin
                  cnt_nxt   = cnt_inc;
                  trail_nxt = trail_r + 1'b1;
                  if (cnt_inc >= MAX_SEG) begin
                    // full run goes out at once
                    hdr_nxt      = run_hdr(cnt_inc);
                    rep_nxt      = last_r;
                    rem_nxt      = CNT_W'(1);
                    body_mem_nxt = 1'b0;
                    state_nxt    = S_HDR;
                    cnt_nxt      = '0;
                    trail_nxt    = '0;
                    head_nxt     = '0;
                    mode_nxt     = MODE_START;
                  end
                end else begin
                  hdr_nxt      = run_hdr(cnt_r);
                  rep_nxt      = last_r;
                  rem_nxt      = CNT_W'(1);
                  body_mem_nxt = 1'b0;
                  state_nxt    = S_HDR;
                  wr_en        = 1'b1;
                  wr_addr      = '0;
                  head_nxt     = '0;
                  cnt_nxt      = CNT_W'(1);
                  trail_nxt    = CNT_W'(1);
                  last_nxt     = in_byte;
                  mode_nxt     = MODE_LIT;
                end
              end
              MODE_LIT: begin
                if (cnt_r >= MAX_SEG) begin
                  // flush full buffer, new byte lands at entry 0 after the last read
                  hdr_nxt      = cnt_r - 1'b1;
                  rd_ptr_nxt   = head_r;
                  rem_nxt      = cnt_r;
                  body_mem_nxt = 1'b1;
                  wr_defer_nxt = 1'b1;
                  state_nxt    = S_HDR;
                  head_nxt     = '0;
                  cnt_nxt      = CNT_W'(1);
                  trail_nxt    = CNT_W'(1);
                  last_nxt     = in_byte;
                end else begin
                  wr_en     = 1'b1;
                  cnt_nxt   = cnt_inc;
                  trail_nxt = trail_new;
                  last_nxt  = in_byte;
                  if (trail_new >= thr) begin
                    mode_nxt = MODE_RUN;
                    cnt_nxt  = trail_new;
                    head_nxt = head_r + lit_len[ADDR_W-1:0];
                    if (lit_len != '0) begin
                      hdr_nxt      = lit_len - 1'b1;
                      rd_ptr_nxt   = head_r;
                      rem_nxt      = lit_len;
                      body_mem_nxt = 1'b1;
                      state_nxt    = S_HDR;
                    end
                  end
                end
              end
              default: begin
                wr_en     = 1'b1;
                wr_addr   = '0;
                head_nxt  = '0;
                cnt_nxt   = CNT_W'(1);
                trail_nxt = CNT_W'(1);
                last_nxt  = in_byte;
                mode_nxt  = MODE_LIT;
              end
            endcase
          end else begin
            end_en_nxt = 1'b1;
            if (mode_r == MODE_LIT) begin
              hdr_nxt      = cnt_r - 1'b1;
              rd_ptr_nxt   = head_r;
              rem_nxt      = cnt_r;
              body_mem_nxt = 1'b1;
              state_nxt    = S_HDR;
            end else if (mode_r == MODE_RUN && cnt_r != '0) begin
              // pending run leaves as a literal of repeated bytes
              hdr_nxt      = cnt_r - 1'b1;
              rep_nxt      = last_r;
              rem_nxt      = cnt_r;
              body_mem_nxt = 1'b0;
              state_nxt    = S_HDR;
            end else begin
              state_nxt = S_END;
            end
            cnt_nxt   = '0;
            trail_nxt = '0;
            head_nxt  = '0;
            last_nxt  = '0;
            mode_nxt  = MODE_START;
          end
        end
      end
      S_HDR: begin
        b_valid    = 1'b1;
        b_out.data = hdr_r;
        if (b_ready) begin
          if (body_mem_r) begin
            rd_en      = 1'b1;
            rd_ptr_nxt = rd_ptr_r + 1'b1;
            state_nxt  = S_MEM;
          end else begin
            state_nxt = S_REP;
          end
        end
      end
      S_MEM: begin
        b_valid    = 1'b1;
        b_out.data = rd_data_r;
        b_out.last = (rem_r == CNT_W'(1)) && !end_en_r;
        if (b_ready) begin
          rem_nxt = rem_r - 1'b1;
          if (rem_r != CNT_W'(1)) begin
            // prefetch the next byte while this one is taken
            rd_en      = 1'b1;
            rd_ptr_nxt = rd_ptr_r + 1'b1;
          end else begin
            if (wr_defer_r) begin
              wr_en        = 1'b1;
              wr_addr      = '0;
              wr_data      = last_r;
              wr_defer_nxt = 1'b0;
            end
            state_nxt = end_en_r ? S_END : S_IDLE;
          end
        end
      end
      S_REP: begin
        b_valid    = 1'b1;
        b_out.data = rep_r;
        b_out.last = (rem_r == CNT_W'(1)) && !end_en_r;
        if (b_ready) begin
          rem_nxt = rem_r - 1'b1;
          if (rem_r == CNT_W'(1)) begin
            state_nxt = end_en_r ? S_END : S_IDLE;
          end
        end
      end
      S_END: begin
        b_valid    = 1'b1;
        b_out.data = END_CODE;
        b_out.last = 1'b1;
        b_out.fin  = 1'b1;
        if (b_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      mode_r     <= MODE_START;
      head_r     <= '0;
      cnt_r      <= '0;
      trail_r    <= '0;
      last_r     <= '0;
      wr_defer_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      mode_r     <= mode_nxt;
      head_r     <= head_nxt;
      cnt_r      <= cnt_nxt;
      trail_r    <= trail_nxt;
      last_r     <= last_nxt;
      wr_defer_r <= wr_defer_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hdr_r      <= hdr_nxt;
    rep_r      <= rep_nxt;
    rem_r      <= rem_nxt;
    rd_ptr_r   <= rd_ptr_nxt;
    body_mem_r <= body_mem_nxt;
    end_en_r   <= end_en_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_ptr_r];
    end
  end

`ifndef SYNTHESIS
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_SEG)
    else $error("pending count above segment limit");

  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_RUN |-> cnt_r >= CNT_W'(2))
    else $error("run mode with fewer than two bytes");

  a_lit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_LIT |-> cnt_r != '0)
    else $error("literal mode with empty buffer");

  a_trail: assert property (@(posedge clk) disable iff (!rst_n)
    trail_r <= cnt_r)
    else $error("trailing run longer than pending bytes");

  a_body_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MEM || state_r == S_REP) |-> rem_r != '0)
    else $error("body state with nothing left to send");
`endif

endmodule

>>> hdl/rle_pack.sv
module rle_pack
  import rle_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       b_valid,
  output logic       b_ready,
  input  rle_byte_t  b_in,
  output logic       out_valid,
  input  logic       out_ready,
  output rle_chunk_t out_chunk
);

  rle_chunk_t acc_r, acc_nxt;
  logic       acc_done_r, acc_done_nxt;
  rle_chunk_t out_r;
  logic       out_valid_r, out_valid_nxt;
  logic       move;

  always_comb begin
    logic [NUM_W-1:0] base_n;
    base_n        = acc_r.count;
    acc_nxt       = acc_r;
    acc_done_nxt  = acc_done_r;
    move          = acc_done_r && (!out_valid_r || out_ready);
    b_ready       = !acc_done_r || move;
    if (move) begin
      acc_done_nxt  = 1'b0;
      base_n        = '0;
      acc_nxt.count = '0;
    end
    if (b_valid && b_ready) begin
      // a fresh chunk starts with zeroed lanes
      if (base_n == '0) begin
        acc_nxt.lanes = '0;
      end
      acc_nxt.lanes[base_n[1:0]] = b_in.data;
      acc_nxt.count = base_n + 1'b1;
      acc_nxt.last  = b_in.last;
      acc_nxt.fin   = b_in.fin;
      acc_done_nxt  = (base_n == NUM_W'(LANES - 1)) || b_in.last;
    end
    out_valid_nxt = move || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      acc_done_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      acc_done_r  <= acc_done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_r <= acc_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_chunk = out_r;

endmodule

>>> hdl/run_length_byte_encoder.sv
// run-length byte encoder, PostScript RunLengthEncode style
// in_*:  one transaction per input item; in_tuser = 0 for a data byte in
//        in_tdata, 1 for end of data. a byte that finishes no segment is
//        taken without leaving idle; the next one can follow in the next cycle.
// out_*: encoded stream packed up to four bytes per transaction, tlast on
//        the final chunk of an input item, tuser on the chunk with the end
//        code. chunks of one item follow in order.
// cfg_*: run threshold (clamped to 2..MAX_SEGMENT), always ready; write it
//        only while the encoder is idle.
// an item that sends encoded bytes holds in_tready low while they go out: one
// byte per cycle leaves the sequencer while the packer is ready, with literal
// bytes read back from the single-port 128-entry buffer into a register ahead
// of being sent. out_tvalid rises once the first chunk is complete and has
// moved from the packer's accumulator to its output register. flushes run up
// to 130 bytes.
// a stalled out_tready backs up through the packer into the sequencer and
// in_tready stays low until all bytes of the item are in the packer.
// reset returns to start mode with threshold 3; buffer contents are not
// cleared and are only read after being written.
module run_length_byte_encoder
  import rle_pkg::*;
#(
  parameter int MAX_SEGMENT = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_data,    // run_threshold
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,    // [7:0] data_byte
  input  logic               in_tuser,    // [0] opcode
  output logic               out_tvalid,
  input  logic               out_tready,
  // [7:0] byte0, [15:8] byte1, [23:16] byte2, [31:24] byte3, [34:32] valid_bytes
  output logic [TDATA_W-1:0] out_tdata,
  output logic               out_tlast,   // chunk_last
  output logic               out_tuser    // [0] stream_end
);

  logic [7:0] thr_r;
  logic       b_valid;
  logic       b_ready;
  rle_byte_t  b_data;
  rle_chunk_t chunk;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_valid) begin
      thr_r <= cfg_data;
    end
  end

  assign cfg_ready = 1'b1;

  rle_ctrl #(
    .MAX_SEGMENT(MAX_SEGMENT)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .thr_cfg  (thr_r),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_op    (in_tuser),
    .in_byte  (in_tdata),
    .b_valid  (b_valid),
    .b_ready  (b_ready),
    .b_out    (b_data)
  );

  rle_pack u_pack (
    .clk       (clk),
    .rst_n     (rst_n),
    .b_valid   (b_valid),
    .b_ready   (b_ready),
    .b_in      (b_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_chunk (chunk)
  );

  assign out_tdata = {{PAD_W{1'b0}}, chunk.count, chunk.lanes};
  assign out_tlast = chunk.last;
  assign out_tuser = chunk.fin;

endmodule

>>> verif/tb.sv
module tb;
  import rle_pkg::*;

  localparam int SEG_MAX       = 128;
  localparam int GAP_MAX       = 17;
  localparam int SETTLE_CYCLES = 12;
  localparam int TIME_LIMIT    = 8_000_000;

  // one packed chunk as it should leave the encoder
  typedef struct packed {
    logic [3:0][7:0] lanes;
    logic [2:0]      valid_bytes;
    logic            chunk_last;
    logic            stream_end;
  } chunk_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [7:0]         cfg_data;
  logic               in_tvalid;
  logic               in_tready;
  logic [7:0]         in_tdata;
  logic               in_tuser;
  logic               out_tvalid;
  logic               out_tready;
  logic [TDATA_W-1:0] out_tdata;
  logic               out_tlast;
  logic               out_tuser;

  chunk_t      expected_chunks[$];
  int unsigned mismatches = 0;
  int unsigned hold_cycles = 0;
  bit          sender_steady = 1'b0;
  bit          receiver_steady = 1'b0;

  // mirror of the encoder state
  rle_mode_t   enc_mode;
  logic [7:0]  lit_buf[SEG_MAX];
  logic [6:0]  lit_head;
  int unsigned pend_cnt;
  int unsigned trail_cnt;
  logic [7:0]  prev_byte;
  logic [7:0]  thr_reg;
  logic [7:0]  enc_bytes[$];

  run_length_byte_encoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned eff_threshold();
    int unsigned t;
    t = thr_reg;
    if (t < 2) t = 2;
    if (t > SEG_MAX) t = SEG_MAX;
    return t;
  endfunction

  function automatic void push_pending(logic [7:0] u);
    lit_buf[(int'(lit_head) + pend_cnt) % SEG_MAX] = u;
    if (pend_cnt == 0 || u != prev_byte) trail_cnt = 1;
    else trail_cnt++;
    prev_byte = u;
    pend_cnt++;
  endfunction

  function automatic void flush_literal(int unsigned len);
    int unsigned i;
    if (len == 0 || len > pend_cnt) return;
    enc_bytes.push_back(8'(len - 1));
    for (i = 0; i < len; i++) begin
      enc_bytes.push_back(lit_buf[lit_head]);
      lit_head = lit_head + 7'd1;
    end
    pend_cnt -= len;
  endfunction

  function automatic void flush_run(int unsigned len);
    enc_bytes.push_back(8'(RUN_BASE - len));
    enc_bytes.push_back(prev_byte);
  endfunction

  function automatic void clear_pending();
    pend_cnt  = 0;
    trail_cnt = 0;
    lit_head  = '0;
  endfunction

  function automatic void restart_with(logic [7:0] u);
    clear_pending();
    push_pending(u);
    enc_mode = MODE_LIT;
  endfunction

  // encode one accepted item and queue the chunks it should produce
  function automatic void encode_item(logic op, logic [7:0] u);
    chunk_t      c;
    int unsigned nres, nv, k, j;
    bit          ended;
    ended = 1'b0;
    enc_bytes.delete();
    if (op == OP_DATA) begin
      if (enc_mode == MODE_RUN) begin
        if (u == prev_byte && pend_cnt < SEG_MAX) begin
          pend_cnt++;
          trail_cnt++;
          if (pend_cnt >= SEG_MAX) begin
            flush_run(pend_cnt);
            clear_pending();
            enc_mode = MODE_START;
          end
        end else begin
          flush_run(pend_cnt);
          restart_with(u);
        end
      end else if (enc_mode == MODE_LIT) begin
        if (pend_cnt >= SEG_MAX) begin
          flush_literal(pend_cnt);
          restart_with(u);
        end else begin
          push_pending(u);
          if (trail_cnt >= eff_threshold()) begin
            flush_literal(pend_cnt - trail_cnt);
            enc_mode = MODE_RUN;
          end
        end
      end else begin
        restart_with(u);
      end
    end else begin
      if (enc_mode == MODE_LIT) begin
        flush_literal(pend_cnt);
      end else if (enc_mode == MODE_RUN && pend_cnt > 0) begin
        // a pending run leaves as a literal of the same bytes
        enc_bytes.push_back(8'(pend_cnt - 1));
        repeat (pend_cnt) enc_bytes.push_back(prev_byte);
      end
      enc_bytes.push_back(END_CODE);
      clear_pending();
      prev_byte = 8'd0;
      enc_mode  = MODE_START;
      ended     = 1'b1;
    end

    nres = (enc_bytes.size() + 3) / 4;
    for (k = 0; k < nres; k++) begin
      c  = '0;
      nv = enc_bytes.size() - 4 * k;
      if (nv > 4) nv = 4;
      for (j = 0; j < nv; j++) c.lanes[j] = enc_bytes[4 * k + j];
      c.valid_bytes = 3'(nv);
      c.chunk_last  = (k + 1 == nres);
      c.stream_end  = ended && (k + 1 == nres);
      expected_chunks.push_back(c);
    end
  endfunction

  function automatic int unsigned draw_wait(bit steady);
    if (steady) return 0;
    case ($urandom_range(0, 3))
      0, 1:    return 0;
      2:       return $urandom_range(1, 3);
      default: return $urandom_range(0, GAP_MAX);
    endcase
  endfunction

  function automatic logic [7:0] other_byte(logic [7:0] prev);
    logic [7:0] u;
    do u = 8'($urandom); while (u == prev);
    return u;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(input logic op, input logic [7:0] u);
    int unsigned gap;
    gap = draw_wait(sender_steady);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= u;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    encode_item(op, u);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_chunks.size() != 0) @(negedge clk);
    // an item with no output may still be in the sequencer
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    thr_reg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_data  <= 8'($urandom);
  endtask

  task automatic send_stream(input int unsigned n_bytes, input int unsigned longest_run);
    logic [7:0]  u;
    int unsigned sent, reps;
    u    = 8'($urandom);
    sent = 0;
    while (sent < n_bytes) begin
      reps = ($urandom_range(0, 2) == 0) ? $urandom_range(2, longest_run) : 1;
      // small alphabet now and then so short runs appear on their own
      if ($urandom_range(0, 9) != 0)
        u = $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 3));
      repeat (reps) send_item(OP_DATA, u);
      sent += reps;
      if ($urandom_range(0, 30) == 0) send_item(OP_END, 8'($urandom));
    end
    send_item(OP_END, 8'($urandom));
  endtask

  task automatic test_directed();
    // end with nothing pending
    send_item(OP_END, 8'hff);
    send_item(OP_DATA, 8'h00);
    send_item(OP_END, 8'h00);
    // literal, then a run closed by a different byte
    send_item(OP_DATA, 8'hff);
    send_item(OP_DATA, 8'h00);
    repeat (4) send_item(OP_DATA, 8'h5a);
    send_item(OP_DATA, 8'ha5);
    send_item(OP_END, 8'h5a);
    // run still pending at end
    repeat (3) send_item(OP_DATA, 8'h33);
    send_item(OP_END, 8'hc3);
    // two equal bytes stay below the threshold
    send_item(OP_DATA, 8'h80);
    send_item(OP_DATA, 8'h80);
    send_item(OP_DATA, 8'h7f);
    send_item(OP_END, 8'h01);
    repeat (3) send_item(OP_DATA, 8'h11);
    send_item(OP_DATA, 8'h22);
    send_item(OP_DATA, 8'h22);
    send_item(OP_END, 8'h00);
  endtask

  task automatic test_segment_limits();
    logic [7:0] u;
    int         i;
    // full literal buffer flushed by the next byte, then a run hitting the maximum
    wait_idle();
    write_threshold(8'd2);
    u = 8'($urandom);
    for (i = 0; i < SEG_MAX; i++) begin
      u = other_byte(u);
      send_item(OP_DATA, u);
    end
    u = other_byte(u);
    repeat (SEG_MAX) send_item(OP_DATA, u);
    send_item(OP_END, 8'($urandom));
  endtask

  task automatic test_random_streams();
    logic [7:0]  thr_list[8];
    int unsigned lim;
    int          p;
    thr_list = '{8'd0, 8'd1, 8'd3, 8'd2, 8'd4, 8'd9, 8'($urandom_range(2, 12)),
                 8'($urandom_range(129, 255))};
    for (p = 0; p < 8; p++) begin
      wait_idle();
      write_threshold(thr_list[p]);
      lim = eff_threshold() + 3;
      if (lim > 16) lim = 16;
      send_stream($urandom_range(1, 10), lim);
    end
  endtask

  task automatic test_backpressure();
    wait_idle();
    write_threshold(8'd2);
    hold_cycles = 250;
    // sender keeps offering while the output is held off
    repeat (2) send_stream($urandom_range(6, 12), 5);
    // sender pauses until everything has drained
    wait_idle();
    send_stream($urandom_range(3, 8), 4);
  endtask

  task automatic test_steady_flow();
    wait_idle();
    write_threshold(THR_RESET);
    sender_steady   = 1'b1;
    receiver_steady = 1'b1;
    repeat (2) send_stream($urandom_range(5, 12), 6);
    sender_steady   = 1'b0;
    receiver_steady = 1'b0;
  endtask

  // receiver
  initial begin
    int unsigned stall;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end
      stall = draw_wait(receiver_steady);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid && hold_cycles == 0) @(posedge clk);
      @(negedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin
    chunk_t want;
    int     j;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_chunks.size() == 0) begin
        $error("result with nothing expected: tdata %h tlast %b tuser %b",
               out_tdata, out_tlast, out_tuser);
        mismatches++;
      end else begin
        want = expected_chunks.pop_front();
        for (j = 0; j < LANES; j++)
          check_field($sformatf("byte%0d", j), want.lanes[j], out_tdata[8*j +: 8]);
        check_field("valid_bytes", want.valid_bytes, out_tdata[LANES*8 +: NUM_W]);
        check_field("chunk_last", want.chunk_last, out_tlast);
        check_field("stream_end", want.stream_end, out_tuser);
      end
    end
  end

  initial begin
    #(TIME_LIMIT);
    $display("run_length_byte_encoder regression: fail");
    $finish;
  end

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= 8'd0;
    in_tuser  <= OP_DATA;
    cfg_valid <= 1'b0;
    cfg_data  <= 8'd0;
    enc_mode  = MODE_START;
    clear_pending();
    prev_byte = 8'd0;
    thr_reg   = THR_RESET;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_streams();
    test_segment_limits();
    test_backpressure();
    test_steady_flow();

    wait_idle();
    if (mismatches == 0)
      $display("run_length_byte_encoder regression: pass");
    else
      $display("run_length_byte_encoder regression: fail");
    $finish;
  end

endmodule
